// ===== sv/swam_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swam_pkg: shared types and constants of the anagram window matcher
// Holds the opcodes, the alphabet size and the work item passed from the
// front to the back of the block.
// ---------------------------------------------------------------------------
package swam_pkg;

    localparam int ALPHABET = 26;
    localparam int LETTER_W = 5;
    localparam int POS_W    = 32;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_PATTERN = 2'd1;
    localparam logic [1:0] OP_TEXT    = 2'd2;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_PATTERN,
        KIND_TEXT
    } t_kind;

    // One classified item on its way to the counter bank.
    typedef struct packed {
        t_kind               kind;
        logic [LETTER_W-1:0] letter;
        logic                leave_en;
        logic [LETTER_W-1:0] leave_letter;
        logic                emit;
        logic [POS_W-1:0]    window_start;
    } t_item;

endpackage

// ===== sv/swam_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swam_ram: generic single-write, single-read RAM
// Read data is registered and returns the old contents when the read and
// the write hit the same address in one cycle.
// ---------------------------------------------------------------------------
module swam_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/swam_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swam_front: input side of the anagram window matcher
// Accepts items, tracks pattern length, ring slot, fill and text position,
// and turns each item into a work item for the counter bank.
// ---------------------------------------------------------------------------
module swam_front #(
    parameter int MAX_PATTERN = 64,
    parameter int QDEPTH      = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic [1:0]                        i_opcode,
    input  logic [swam_pkg::LETTER_W-1:0]     i_letter,
    input  logic [$clog2(QDEPTH+1)-1:0]       i_q_count,
    output logic                              o_full,
    output logic                              o_item_valid,
    output swam_pkg::t_item                   o_item
);

    import swam_pkg::*;

    localparam int PLW = $clog2(MAX_PATTERN + 1);
    localparam int AW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CNW = $clog2(QDEPTH + 1);

    logic              r_started, n_started;
    logic [PLW-1:0]    r_plen, n_plen;
    logic [PLW-1:0]    r_fill, n_fill;
    logic [AW-1:0]     r_slot, n_slot;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_s1_valid, n_s1_valid;
    t_item             r_s1, n_s1;

    logic                accept;
    logic                letter_ok;
    logic                text_go;
    logic                win_full;
    logic [CNW:0]        used;
    logic [LETTER_W-1:0] leave_letter;

    // A slot is held back for the item sitting in the stage register.
    assign used   = {1'b0, i_q_count} + {{CNW{1'b0}}, r_s1_valid};
    assign o_full = used >= (CNW + 1)'(QDEPTH);
    assign accept = i_push && !o_full;

    assign letter_ok = i_letter < LETTER_W'(ALPHABET);
    assign win_full  = r_fill == r_plen;

    always_comb begin
        n_started  = r_started;
        n_plen     = r_plen;
        n_fill     = r_fill;
        n_slot     = r_slot;
        n_pos      = r_pos;
        n_s1_valid = 1'b0;
        n_s1       = r_s1;
        text_go    = 1'b0;
        n_s1.letter       = i_letter;
        n_s1.leave_en     = 1'b0;
        n_s1.leave_letter = '0;
        n_s1.emit         = 1'b0;
        n_s1.window_start = r_pos + POS_W'(1) - POS_W'(r_plen);
        if (accept) begin
            case (i_opcode)
                OP_CLEAR: begin
                    n_started  = 1'b0;
                    n_plen     = '0;
                    n_fill     = '0;
                    n_slot     = '0;
                    n_pos      = '0;
                    n_s1_valid = 1'b1;
                    n_s1.kind  = KIND_CLEAR;
                end
                OP_PATTERN: begin
                    if (letter_ok && !r_started && r_plen != PLW'(MAX_PATTERN)) begin
                        n_plen     = r_plen + PLW'(1);
                        n_s1_valid = 1'b1;
                        n_s1.kind  = KIND_PATTERN;
                    end
                end
                OP_TEXT: begin
                    if (letter_ok) begin
                        n_started = 1'b1;
                        if (r_plen != '0) begin
                            text_go       = 1'b1;
                            n_s1_valid    = 1'b1;
                            n_s1.kind     = KIND_TEXT;
                            n_s1.leave_en = win_full;
                            n_s1.emit     = win_full || (r_fill + PLW'(1) == r_plen);
                            n_pos         = r_pos + POS_W'(1);
                            if (!win_full) begin
                                n_fill = r_fill + PLW'(1);
                            end
                            if (PLW'(r_slot) + PLW'(1) == r_plen) begin
                                n_slot = '0;
                            end else begin
                                n_slot = r_slot + AW'(1);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_plen     <= '0;
            r_fill     <= '0;
            r_slot     <= '0;
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_started  <= n_started;
            r_plen     <= n_plen;
            r_fill     <= n_fill;
            r_slot     <= n_slot;
            r_pos      <= n_pos;
            r_s1_valid <= n_s1_valid;
        end
        r_s1 <= n_s1;
    end

    // The ring is read and written at the same slot; the old letter comes
    // back in the next cycle, lined up with the stage register.
    swam_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (MAX_PATTERN)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (text_go),
        .i_waddr (r_slot),
        .i_wdata (i_letter),
        .i_raddr (r_slot),
        .o_rdata (leave_letter)
    );

    always_comb begin
        o_item              = r_s1;
        o_item.leave_letter = leave_letter;
    end
    assign o_item_valid = r_s1_valid;

    a_slot_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_plen != '0) |-> (PLW'(r_slot) < r_plen))
        else $error("ring slot outside pattern length");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_plen)
        else $error("window fill exceeds pattern length");

endmodule

// ===== sv/swam_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swam_queue: short work queue between front and back
// A small register FIFO; the head entry is visible while it is not empty.
// ---------------------------------------------------------------------------
module swam_queue #(
    parameter int DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  swam_pkg::t_item               i_wdata,
    input  logic                          i_rd,
    output logic                          o_valid,
    output swam_pkg::t_item               o_rdata,
    output logic [$clog2(DEPTH+1)-1:0]    o_count
);

    import swam_pkg::*;

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_head, n_head;
    logic [AW-1:0]  r_tail, n_tail;
    logic [CNW-1:0] r_count, n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_wr) begin
            n_tail = (32'(r_tail) == DEPTH - 1) ? '0 : r_tail + AW'(1);
        end
        if (i_rd) begin
            n_head = (32'(r_head) == DEPTH - 1) ? '0 : r_head + AW'(1);
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + CNW'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - CNW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
        if (i_wr) begin
            r_mem[r_tail] <= i_wdata;
        end
    end

    assign o_valid = r_count != '0;
    assign o_rdata = r_mem[r_head];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (r_count != CNW'(DEPTH) || i_rd))
        else $error("work queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> (r_count != '0))
        else $error("work queue underflow");

endmodule

// ===== sv/swam_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swam_back: letter counter bank and result register
// Keeps one difference per letter (window count minus pattern count) and
// produces the match result for each item that completes a window.
// ---------------------------------------------------------------------------
module swam_back #(
    parameter int MAX_PATTERN = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  swam_pkg::t_item               i_item,
    output logic                          o_take,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic                          o_is_anagram,
    output logic [swam_pkg::POS_W-1:0]    o_window_start
);

    import swam_pkg::*;

    // Two's complement difference, wide enough for +/- MAX_PATTERN.
    localparam int CW = $clog2(MAX_PATTERN + 1) + 1;

    logic [CW-1:0]    r_diff [ALPHABET];
    logic [CW-1:0]    n_diff [ALPHABET];
    logic             r_out_valid, n_out_valid;
    logic             r_match;
    logic [POS_W-1:0] r_start;
    logic             all_zero_next;
    logic             all_zero_now;
    logic             out_taken;

    assign out_taken = i_pop && r_out_valid;
    // An item that gives no result never waits on the output register.
    assign o_take = i_valid && (!i_item.emit || !r_out_valid || out_taken);

    // Each lane sees at most one increment and one decrement per item.
    always_comb begin
        all_zero_next = 1'b1;
        all_zero_now  = 1'b1;
        for (int i = 0; i < ALPHABET; i++) begin
            n_diff[i] = r_diff[i];
            if (i_item.kind == KIND_CLEAR) begin
                n_diff[i] = '0;
            end else if (i_item.kind == KIND_PATTERN) begin
                if (i_item.letter == LETTER_W'(i)) begin
                    n_diff[i] = r_diff[i] - CW'(1);
                end
            end else begin
                if (i_item.letter == LETTER_W'(i)) begin
                    n_diff[i] = n_diff[i] + CW'(1);
                end
                if (i_item.leave_en && i_item.leave_letter == LETTER_W'(i)) begin
                    n_diff[i] = n_diff[i] - CW'(1);
                end
            end
            if (n_diff[i] != '0) begin
                all_zero_next = 1'b0;
            end
            if (r_diff[i] != '0) begin
                all_zero_now = 1'b0;
            end
        end
    end

    assign n_out_valid = (r_out_valid && !out_taken) || (o_take && i_item.emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < ALPHABET; i++) begin
                r_diff[i] <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                for (int i = 0; i < ALPHABET; i++) begin
                    r_diff[i] <= n_diff[i];
                end
            end
        end
        if (o_take && i_item.emit) begin
            r_match <= all_zero_next;
            r_start <= i_item.window_start;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_is_anagram   = r_match;
    assign o_window_start = r_start;

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.kind == KIND_CLEAR) |=> all_zero_now)
        else $error("counters not zero after clear");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> r_out_valid)
        else $error("waiting result lost");

    a_emit_only_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.emit) |-> (i_item.kind == KIND_TEXT))
        else $error("result from a non-text item");

endmodule

// ===== sv/sliding_window_anagram_match.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliding_window_anagram_match: streaming anagram search over a text
// Finds every window of the text that is a permutation of the pattern.
// ---------------------------------------------------------------------------
// Usage. The input side is a queue: drive opcode and letter and raise push;
// the transfer happens on a clock edge where push is high and full is low.
// Opcode clear wipes the pattern, window and counters, pattern letters build
// the pattern, and text letters slide the window. The result side is a queue
// as well: while empty is low, is_anagram and window_start show the oldest
// result, and the transfer happens on an edge where pop is high.
// Each text letter that completes a window of pattern length gives exactly
// one result; every other item gives none.
// A text letter that completes a window passes the front stage register,
// the work queue and the output register, where its result shows.
// Throughput: one item per cycle while full is low. Each text letter touches
// one ring slot in the history RAM and at most two letter counters.
// When the receiver stalls, results wait in the output register and items
// collect in the work queue; full rises once the queue and the front stage
// hold QDEPTH items. After reset the block is empty and takes items at once.
// ---------------------------------------------------------------------------
module sliding_window_anagram_match #(
    parameter int MAX_PATTERN = 64,
    parameter int QDEPTH      = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_opcode,
    input  logic [swam_pkg::LETTER_W-1:0]     i_letter,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_is_anagram,
    output logic [swam_pkg::POS_W-1:0]        o_window_start
);

    import swam_pkg::*;

    // Front stage output, which always lands in the queue on the next edge.
    logic                          front_valid;
    t_item                         front_item;
    // Queue head toward the counter bank.
    logic                          q_valid;
    t_item                         q_item;
    logic [$clog2(QDEPTH+1)-1:0]   q_count;
    logic                          back_take;

    // The front classifies each transfer and keeps all position bookkeeping,
    // including the ring of recent text letters.
    swam_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .QDEPTH      (QDEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_opcode     (i_opcode),
        .i_letter     (i_letter),
        .i_q_count    (q_count),
        .o_full       (full),
        .o_item_valid (front_valid),
        .o_item       (front_item)
    );

    // The queue decouples the two halves, so a stalled receiver does not
    // stop input transfers until the queue fills up.
    swam_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_valid),
        .i_wdata (front_item),
        .i_rd    (back_take),
        .o_valid (q_valid),
        .o_rdata (q_item),
        .o_count (q_count)
    );

    // The back applies counter updates in order and holds the result.
    swam_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_take         (back_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_is_anagram   (o_is_anagram),
        .o_window_start (o_window_start)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the sliding window anagram matcher
// Streams clears, pattern letters and text letters into the block through
// its input queue and drains its result queue, both with random idling.
// A predictor inside the bench tracks the letter differences and the
// window ring, and every result is compared with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;

    import swam_pkg::*;

    localparam int          PATTERN_CAP  = 64;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int          LIVE_TARGET  = 1700;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          DRAIN_CYCLES = 100;

    // One input transfer, with the number of idle cycles that follow it.
    typedef struct {
        logic [1:0]          op;
        logic [LETTER_W-1:0] letter;
        int                  idle;
    } t_stim;

    // One predicted window result.
    typedef struct packed {
        bit             is_anagram;
        bit [POS_W-1:0] window_start;
    } t_window_result;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                push     = 1'b0;
    logic                pop      = 1'b0;
    logic [1:0]          i_opcode = OP_CLEAR;
    logic [LETTER_W-1:0] i_letter = '0;
    logic                full;
    logic                empty;
    logic                o_is_anagram;
    logic [POS_W-1:0]    o_window_start;

    sliding_window_anagram_match #(
        .MAX_PATTERN(PATTERN_CAP)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_opcode      (i_opcode),
        .i_letter      (i_letter),
        .empty         (empty),
        .pop           (pop),
        .o_is_anagram  (o_is_anagram),
        .o_window_start(o_window_start)
    );

    // 20 ns period: ten nanoseconds low, then ten high.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Predictor state. It mirrors the block: one signed difference per letter
    // (window count minus pattern count), the number of nonzero differences,
    // the pattern length, the text position and a ring of recent text letters.
    // -----------------------------------------------------------------------
    int                  diff_cnt [ALPHABET];
    int                  nonzero_cnt;
    int                  pat_len;
    bit [POS_W-1:0]      text_pos;
    logic [LETTER_W-1:0] history [PATTERN_CAP];
    bit                  text_seen;
    int                  ring_slot;
    int                  ring_fill;

    // Items waiting to be driven, and results waiting to come out.
    t_stim               stim_q [$];
    t_window_result      pending_windows [$];

    int                  stim_total;
    int                  live_items;
    int                  accepted_cnt;
    int                  result_cnt;
    int                  match_cnt;
    int                  clear_cnt;
    int                  fail_cnt;
    int                  cycle_cnt;
    int                  gap_left;
    int                  stall_left;
    bit                  calm_in;
    bit                  in_xfer;
    bit                  produced;
    t_window_result      predicted;
    t_window_result      want;

    // Returns every piece of predicted state to its reset value. The ring
    // contents are left alone: a slot is only read after it has been written.
    function automatic void clear_window();
        foreach (diff_cnt[i]) diff_cnt[i] = 0;
        nonzero_cnt = 0;
        pat_len     = 0;
        text_pos    = '0;
        text_seen   = 1'b0;
        ring_slot   = 0;
        ring_fill   = 0;
    endfunction

    // Moves one letter difference and keeps the nonzero count in step.
    function automatic void bump_letter(int code, int delta);
        bit was_nonzero;
        was_nonzero = diff_cnt[code] != 0;
        diff_cnt[code] += delta;
        if (was_nonzero && diff_cnt[code] == 0)
            nonzero_cnt--;
        else if (!was_nonzero && diff_cnt[code] != 0)
            nonzero_cnt++;
    endfunction

    // Applies one accepted item to the predicted state. A text letter that
    // completes a full window gives one result; nothing else does.
    task automatic slide_window(input logic [1:0] op, input logic [LETTER_W-1:0] code,
                                output bit has_result, output t_window_result res);
        int leaving;
        has_result = 1'b0;
        res        = '0;
        if (op == OP_CLEAR) begin
            clear_window();
            return;
        end
        if (op == OP_UNUSED || code >= ALPHABET)
            return;
        if (op == OP_PATTERN) begin
            // Pattern letters are dropped once text has begun or the pattern is full.
            if (text_seen || pat_len >= PATTERN_CAP)
                return;
            bump_letter(code, -1);
            pat_len++;
            return;
        end
        text_seen = 1'b1;
        // With no pattern, a text letter only marks that text has begun.
        if (pat_len == 0)
            return;
        // The entering letter is counted first, then the leaving one.
        bump_letter(code, 1);
        if (ring_slot >= pat_len)
            ring_slot = 0;
        if (ring_fill >= pat_len) begin
            leaving = history[ring_slot];
            bump_letter(leaving, -1);
        end else begin
            ring_fill++;
        end
        history[ring_slot] = code;
        ring_slot++;
        if (ring_slot >= pat_len)
            ring_slot = 0;
        text_pos = text_pos + 1;
        if (ring_fill < pat_len)
            return;
        has_result         = 1'b1;
        res.is_anagram     = nonzero_cnt == 0;
        res.window_start   = text_pos - pat_len;
    endtask

    // Idle lengths: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Queues one item. During a calm stretch it is followed by no idle cycle.
    task automatic add_item(input logic [1:0] op, input int letter);
        t_stim it;
        it.op     = op;
        it.letter = LETTER_W'(letter);
        it.idle   = calm_in ? 0 : pick_gap();
        stim_q.push_back(it);
        if (op != OP_UNUSED && letter < ALPHABET)
            live_items++;
    endtask

    // -----------------------------------------------------------------------
    // Input driver. It changes the inputs only at the falling edge. An item
    // stays on the ports with push high until a rising edge sees full low;
    // after the transfer it waits out the item's idle cycles. A push that is
    // to stay high for the next item is never lowered in between.
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_stim it;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !in_xfer) begin
            // Held by backpressure: keep the same item on the ports.
        end else if (gap_left > 0) begin
            push     <= 1'b0;
            gap_left  = gap_left - 1;
        end else if (stim_q.size() > 0) begin
            it        = stim_q.pop_front();
            i_opcode <= it.op;
            i_letter <= it.letter;
            push     <= 1'b1;
            gap_left  = it.idle;
        end else begin
            push <= 1'b0;
        end
    end

    // -----------------------------------------------------------------------
    // Result side. The receiver stalls at random, independent of whether a
    // result is waiting, so that stalls land on every phase of the pipeline.
    // At regular intervals there is a stretch in which no new stall begins.
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            pop        <= 1'b0;
            stall_left  = stall_left - 1;
        end else begin
            pop <= 1'b1;
            if ((cycle_cnt % 3000) >= 600 && $urandom_range(0, 2) == 0)
                stall_left = pick_gap();
        end
    end

    // -----------------------------------------------------------------------
    // Monitor. At each rising edge it records an input transfer and feeds it
    // to the predictor, then checks a result transfer against the oldest
    // prediction. The block's outputs are read before its own updates land.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_xfer = i_rst_n && push && !full;
        if (in_xfer) begin
            accepted_cnt++;
            if (i_opcode == OP_CLEAR)
                clear_cnt++;
            slide_window(i_opcode, i_letter, produced, predicted);
            if (produced)
                pending_windows.push_back(predicted);
        end
        if (i_rst_n && pop && !empty) begin
            result_cnt++;
            if (pending_windows.size() == 0) begin
                $error("unexpected result: is_anagram %0d, window_start %0d",
                       o_is_anagram, o_window_start);
                fail_cnt++;
            end else begin
                want = pending_windows.pop_front();
                if (want.is_anagram)
                    match_cnt++;
                if (o_is_anagram !== want.is_anagram) begin
                    $error("is_anagram: expected %0d, got %0d",
                           want.is_anagram, o_is_anagram);
                    fail_cnt++;
                end
                if (o_window_start !== want.window_start) begin
                    $error("window_start: expected %0d, got %0d",
                           want.window_start, o_window_start);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run. The whole item list is built at time zero,
    // reset is applied once, and the run ends after the last result drains.
    // -----------------------------------------------------------------------
    initial begin
        int                  r;
        int                  plen;
        int                  eff_len;
        int                  tlen;
        int                  base;
        int                  span;
        int                  sent;
        int                  j;
        int                  tmp;
        logic [LETTER_W-1:0] pat [PATTERN_CAP+4];
        logic [LETTER_W-1:0] perm [PATTERN_CAP];

        clear_window();
        calm_in = 1'b1;

        // Directed part. Text before any pattern gives nothing, and a pattern
        // letter after that text is dropped until a clear.
        add_item(OP_TEXT, 3);
        add_item(OP_PATTERN, 0);
        add_item(OP_TEXT, 7);
        add_item(OP_CLEAR, 31);
        // Pattern "az", with an unused opcode and out-of-range letters mixed in.
        add_item(OP_PATTERN, 0);
        add_item(OP_PATTERN, 25);
        add_item(OP_UNUSED, 5);
        add_item(OP_PATTERN, 26);
        add_item(OP_TEXT, 31);
        // The first text letter is a partial window; then za, aa and az.
        add_item(OP_TEXT, 25);
        add_item(OP_TEXT, 0);
        add_item(OP_TEXT, 0);
        add_item(OP_TEXT, 25);
        add_item(OP_PATTERN, 1);
        add_item(OP_TEXT, 16);
        // Alternating letter bits in a fresh pattern.
        add_item(OP_CLEAR, 0);
        add_item(OP_PATTERN, 31);
        add_item(OP_PATTERN, 21);
        add_item(OP_PATTERN, 10);
        add_item(OP_TEXT, 10);
        add_item(OP_TEXT, 21);
        add_item(OP_TEXT, 10);
        add_item(OP_TEXT, 3);

        // Random part: mostly a clear, a pattern and a text drawn from a few
        // nearby letters so that anagram windows are common, with noise items
        // and the occasional missing clear in between.
        while (live_items < LIVE_TARGET) begin
            calm_in = $urandom_range(0, 4) == 0;
            r = $urandom_range(0, 99);
            if (r < 8) begin
                repeat ($urandom_range(1, 6))
                    add_item(2'($urandom_range(0, 3)), $urandom_range(0, 31));
            end else begin
                if ($urandom_range(0, 9) != 0)
                    add_item(OP_CLEAR, $urandom_range(0, 31));
                r = $urandom_range(0, 99);
                if (r < 3)
                    plen = 0;
                else if (r < 10)
                    plen = $urandom_range(PATTERN_CAP - 4, PATTERN_CAP + 3);
                else if (r < 25)
                    plen = $urandom_range(9, 20);
                else
                    plen = $urandom_range(1, 8);
                eff_len = (plen > PATTERN_CAP) ? PATTERN_CAP : plen;
                base = $urandom_range(0, ALPHABET - 1);
                span = $urandom_range(1, 6);
                for (int i = 0; i < plen; i++) begin
                    pat[i] = LETTER_W'((base + $urandom_range(0, span - 1)) % ALPHABET);
                    add_item(OP_PATTERN, pat[i]);
                    if ($urandom_range(0, 29) == 0)
                        add_item(OP_UNUSED, $urandom_range(0, 31));
                end
                tlen = (plen == 0) ? $urandom_range(1, 4) : eff_len + $urandom_range(0, 24);
                sent = 0;
                while (sent < tlen) begin
                    r = $urandom_range(0, 99);
                    if (r < 4) begin
                        case ($urandom_range(0, 2))
                            0: add_item(OP_UNUSED, $urandom_range(0, 31));
                            1: add_item(OP_TEXT, $urandom_range(ALPHABET, 31));
                            default: add_item(OP_PATTERN, $urandom_range(0, ALPHABET - 1));
                        endcase
                    end else if (r < 25 && eff_len > 0) begin
                        // A shuffled copy of the pattern forces a matching window.
                        for (int i = 0; i < eff_len; i++)
                            perm[i] = pat[i];
                        for (int i = eff_len - 1; i > 0; i--) begin
                            j       = $urandom_range(0, i);
                            tmp     = perm[i];
                            perm[i] = perm[j];
                            perm[j] = LETTER_W'(tmp);
                        end
                        for (int i = 0; i < eff_len; i++)
                            add_item(OP_TEXT, perm[i]);
                        sent += eff_len;
                    end else if (r < 90) begin
                        add_item(OP_TEXT, (base + $urandom_range(0, span - 1)) % ALPHABET);
                        sent++;
                    end else begin
                        add_item(OP_TEXT, $urandom_range(0, ALPHABET - 1));
                        sent++;
                    end
                end
            end
        end
        stim_total = stim_q.size();

        // Reset is held low from time zero and released at a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt < stim_total)
            @(negedge i_clk);
        while (pending_windows.size() != 0)
            @(negedge i_clk);
        // Any stray result would surface within this drain time.
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d input transfers including %0d clears; checked %0d window results.",
                 accepted_cnt, clear_cnt, result_cnt);
        $display("Of those windows %0d were anagram matches; %0d mismatches were found.",
                 match_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
